FILE: hw/rtl/fcsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame change spike detector package
// Shared widths, constants, controller states and control structs.
// ----------------------------------------------------------------------------
package fcsd_pkg;

    localparam int WINDOW_SIZE = 20;

    localparam int COORD_W  = 12;
    localparam int COLOR_W  = 24;
    localparam int COUNT_W  = 8;
    localparam int TOTAL_W  = 20;
    localparam int FRAMES_W = 16;
    localparam int CHANGE_W = 36;
    localparam int PROD_W   = TOTAL_W + COUNT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int DIV_CNT_W  = 6;
    localparam int DIV_STEPS  = CHANGE_W;

    localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = '1;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX = '1;
    localparam logic [CHANGE_W-1:0] CHANGE_MAX = '1;

    localparam logic [COUNT_W-1:0] WARMUP_RESET = 8'd10;
    localparam logic [COUNT_W-1:0] ARM_RESET    = 8'd20;
    localparam logic [COUNT_W-1:0] FACTOR_RESET = 8'd9;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_FRAMES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_FRAMES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPIKE_FACTOR  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_ACCUM,
        S_DLOAD,
        S_DIV,
        S_AVG,
        S_MULT,
        S_CMP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic pixel_accept;
        logic do_diff;
        logic do_accum;
        logic div_load;
        logic div_step;
        logic do_avg;
        logic do_mult;
        logic do_cmp;
    } cmd_t;

    typedef struct packed {
        logic latched;
        logic frames_zero;
        logic div_last;
    } status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fcsd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame change spike detector controller
// Sequences the frame-end steps: difference, total, divide, threshold, result.
// ----------------------------------------------------------------------------
module fcsd_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             frame_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output fcsd_pkg::cmd_t        cmd,
    input  wire fcsd_pkg::status_t status
);
    import fcsd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && frame_last && !status.latched)
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:  state_next = S_ACCUM;
            S_ACCUM: state_next = S_DLOAD;
            S_DLOAD: state_next = status.frames_zero ? S_AVG : S_DIV;
            S_DIV:   state_next = status.div_last ? S_AVG : S_DIV;
            S_AVG:   state_next = S_MULT;
            S_MULT:  state_next = S_CMP;
            S_CMP:   state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready         = 1'b1;
                cmd.pixel_accept = in_valid;
            end
            S_DIFF:  cmd.do_diff  = 1'b1;
            S_ACCUM: cmd.do_accum = 1'b1;
            S_DLOAD: cmd.div_load = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_AVG:   cmd.do_avg   = 1'b1;
            S_MULT:  cmd.do_mult  = 1'b1;
            S_CMP:   cmd.do_cmp   = 1'b1;
            S_OUT:   out_valid    = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/fcsd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame change spike detector datapath
// Configuration, window summing, frame totals, serial divider and threshold.
// ----------------------------------------------------------------------------
module fcsd_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [fcsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fcsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [fcsd_pkg::COORD_W-1:0]       pixel_x,
    input  wire logic [fcsd_pkg::COORD_W-1:0]       pixel_y,
    input  wire logic [fcsd_pkg::COLOR_W-1:0]       pixel_color,
    input  wire logic                               frame_last,
    input  wire fcsd_pkg::cmd_t                     cmd,
    output fcsd_pkg::status_t                       status,
    output logic                                    spike_found,
    output logic [fcsd_pkg::TOTAL_W-1:0]            frame_change,
    output logic [fcsd_pkg::TOTAL_W-1:0]            average_change,
    output logic [fcsd_pkg::FRAMES_W-1:0]           frame_number
);
    import fcsd_pkg::*;

    logic [COORD_W-1:0]  window_left_reg;
    logic [COORD_W-1:0]  window_top_reg;
    logic [COUNT_W-1:0]  warmup_reg;
    logic [COUNT_W-1:0]  arm_reg;
    logic [COUNT_W-1:0]  factor_reg;

    logic [TOTAL_W-1:0]  window_total_reg;
    logic [TOTAL_W-1:0]  current_reg;
    logic [TOTAL_W-1:0]  previous_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic [CHANGE_W-1:0] change_total_reg;
    logic                latched_reg;

    logic [TOTAL_W-1:0]  change_reg;
    logic [FRAMES_W-1:0] number_reg;
    logic [TOTAL_W-1:0]  average_reg;
    logic [PROD_W-1:0]   product_reg;
    logic                spike_reg;

    logic [CHANGE_W-1:0]  dividend_reg;
    logic [FRAMES_W-1:0]  remainder_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [COORD_W:0]    x_end;
    logic [COORD_W:0]    y_end;
    logic                in_window;
    logic [TOTAL_W:0]    pixel_sum;
    logic [TOTAL_W-1:0]  window_sum;
    logic [CHANGE_W:0]   accum_sum;
    logic [FRAMES_W:0]   rem_shift;
    logic                rem_ge;

    always_comb
    begin
        x_end = {1'b0, window_left_reg} + (COORD_W+1)'(WINDOW_SIZE);
        y_end = {1'b0, window_top_reg} + (COORD_W+1)'(WINDOW_SIZE);
        in_window = (pixel_x >= window_left_reg) && ({1'b0, pixel_x} < x_end) &&
                    (pixel_y >= window_top_reg) && ({1'b0, pixel_y} < y_end);
        pixel_sum = {1'b0, window_total_reg} + (TOTAL_W+1)'(pixel_color[23:16]);
        if (!in_window)
        begin
            window_sum = window_total_reg;
        end
        else if (pixel_sum[TOTAL_W])
        begin
            window_sum = TOTAL_MAX;
        end
        else
        begin
            window_sum = pixel_sum[TOTAL_W-1:0];
        end
        accum_sum = {1'b0, change_total_reg} + (CHANGE_W+1)'(change_reg);
        rem_shift = {remainder_reg, dividend_reg[CHANGE_W-1]};
        rem_ge    = rem_shift >= {1'b0, frames_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_left_reg <= '0;
            window_top_reg  <= '0;
            warmup_reg      <= WARMUP_RESET;
            arm_reg         <= ARM_RESET;
            factor_reg      <= FACTOR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WINDOW_LEFT:   window_left_reg <= cfg_data;
                REG_WINDOW_TOP:    window_top_reg  <= cfg_data;
                REG_WARMUP_FRAMES: warmup_reg      <= cfg_data[COUNT_W-1:0];
                REG_ARM_FRAMES:    arm_reg         <= cfg_data[COUNT_W-1:0];
                REG_SPIKE_FACTOR:  factor_reg      <= cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_total_reg <= '0;
            previous_reg     <= '0;
            frames_reg       <= '0;
            change_total_reg <= '0;
            latched_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.pixel_accept && !latched_reg)
            begin
                window_total_reg <= frame_last ? '0 : window_sum;
            end
            if (cmd.do_diff)
            begin
                previous_reg <= current_reg;
            end
            if (cmd.do_accum && (frames_reg > FRAMES_W'(warmup_reg)))
            begin
                change_total_reg <= accum_sum[CHANGE_W] ? CHANGE_MAX
                                                        : accum_sum[CHANGE_W-1:0];
            end
            if (cmd.do_cmp)
            begin
                if ((frames_reg > FRAMES_W'(arm_reg)) &&
                    (PROD_W'(change_reg) > product_reg))
                begin
                    latched_reg <= 1'b1;
                end
                else if (frames_reg != FRAMES_MAX)
                begin
                    frames_reg <= frames_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pixel_accept && !latched_reg && frame_last)
        begin
            current_reg <= window_sum;
        end
        if (cmd.do_diff)
        begin
            change_reg <= (previous_reg > current_reg) ? previous_reg - current_reg
                                                       : current_reg - previous_reg;
            number_reg <= frames_reg;
        end
        if (cmd.div_load)
        begin
            dividend_reg  <= change_total_reg;
            remainder_reg <= '0;
            div_cnt_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg  <= {dividend_reg[CHANGE_W-2:0], rem_ge};
            remainder_reg <= rem_ge ? FRAMES_W'(rem_shift - {1'b0, frames_reg})
                                    : rem_shift[FRAMES_W-1:0];
            div_cnt_reg   <= div_cnt_reg + 1'b1;
        end
        if (cmd.do_avg)
        begin
            if (frames_reg == '0)
            begin
                average_reg <= '0;
            end
            else if (dividend_reg[CHANGE_W-1:TOTAL_W] != '0)
            begin
                average_reg <= TOTAL_MAX;
            end
            else
            begin
                average_reg <= dividend_reg[TOTAL_W-1:0];
            end
        end
        if (cmd.do_mult)
        begin
            product_reg <= PROD_W'(average_reg) * PROD_W'(factor_reg);
        end
        if (cmd.do_cmp)
        begin
            spike_reg <= (frames_reg > FRAMES_W'(arm_reg)) &&
                         (PROD_W'(change_reg) > product_reg);
        end
    end

    always_comb
    begin
        status.latched     = latched_reg;
        status.frames_zero = (frames_reg == '0);
        status.div_last    = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        spike_found        = spike_reg;
        frame_change       = change_reg;
        average_change     = average_reg;
        frame_number       = number_reg;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/frame_change_spike_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame change spike detector
// Sums the red byte inside a square window per frame and flags sudden changes.
// ----------------------------------------------------------------------------
// Pixels that are not the last of a frame are taken one beat per cycle. The
// last pixel of a frame starts the frame-end sequence, and no further pixel
// is taken until its result beat has been delivered. The divide is skipped on
// the first frame; on later frames the result waits for the one-bit-per-cycle
// divider that forms the average over 36 quotient bits. After a spike every
// pixel is taken and discarded and no result is produced until reset.
module frame_change_spike_detector (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [fcsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fcsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [fcsd_pkg::COORD_W-1:0]       pixel_x,
    input  wire logic [fcsd_pkg::COORD_W-1:0]       pixel_y,
    input  wire logic [fcsd_pkg::COLOR_W-1:0]       pixel_color,
    input  wire logic                               frame_last,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    spike_found,
    output logic [fcsd_pkg::TOTAL_W-1:0]            frame_change,
    output logic [fcsd_pkg::TOTAL_W-1:0]            average_change,
    output logic [fcsd_pkg::FRAMES_W-1:0]           frame_number
);
    import fcsd_pkg::*;

    cmd_t    cmd;
    status_t status;

    fcsd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .frame_last (frame_last),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .status     (status)
    );

    fcsd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .pixel_color    (pixel_color),
        .frame_last     (frame_last),
        .cmd            (cmd),
        .status         (status),
        .spike_found    (spike_found),
        .frame_change   (frame_change),
        .average_change (average_change),
        .frame_number   (frame_number)
    );

endmodule
`default_nettype wire

FILE: tb/frame_change_spike_detector_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame change spike detector checker
// Watches the register port and both channels, keeps its own copy of the
// window sum, frame count and change total, predicts the result of every
// frame end and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_change_spike_detector_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [fcsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fcsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic [fcsd_pkg::COORD_W-1:0]       pixel_x,
    input  wire logic [fcsd_pkg::COORD_W-1:0]       pixel_y,
    input  wire logic [fcsd_pkg::COLOR_W-1:0]       pixel_color,
    input  wire logic                               frame_last,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic                               spike_found,
    input  wire logic [fcsd_pkg::TOTAL_W-1:0]       frame_change,
    input  wire logic [fcsd_pkg::TOTAL_W-1:0]       average_change,
    input  wire logic [fcsd_pkg::FRAMES_W-1:0]      frame_number,
    output int                                      mismatches,
    output int                                      pending
);
    import fcsd_pkg::*;

    typedef struct packed {
        logic                spike;
        logic [TOTAL_W-1:0]  change;
        logic [TOTAL_W-1:0]  average;
        logic [FRAMES_W-1:0] number;
    } frame_result_t;

    logic [COORD_W-1:0]  win_left;
    logic [COORD_W-1:0]  win_top;
    logic [COUNT_W-1:0]  warmup;
    logic [COUNT_W-1:0]  arm;
    logic [COUNT_W-1:0]  factor;

    logic [TOTAL_W-1:0]  window_sum;
    logic [TOTAL_W-1:0]  prev_sum;
    logic [FRAMES_W-1:0] frame_count;
    logic [CHANGE_W-1:0] change_sum;
    logic                frozen;

    frame_result_t expected_frames[$];
    int error_count;
    int result_count;

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        if (error_count < 10)
        begin
            $display("Frame result %0d, %s: expected %0d, got %0d",
                     result_count, field, want, got);
        end
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        frame_result_t       oldest;
        frame_result_t       predicted;
        logic [TOTAL_W:0]    sum_ext;
        logic [CHANGE_W:0]   total_ext;
        logic [CHANGE_W-1:0] quotient;
        logic [TOTAL_W-1:0]  current;
        logic [TOTAL_W-1:0]  change;
        logic [TOTAL_W-1:0]  average;
        logic [PROD_W-1:0]   threshold;
        logic                spike;

        if (!rst_n)
        begin
            win_left = '0;
            win_top = '0;
            warmup = WARMUP_RESET;
            arm = ARM_RESET;
            factor = FACTOR_RESET;
            window_sum = '0;
            prev_sum = '0;
            frame_count = '0;
            change_sum = '0;
            frozen = 1'b0;
            expected_frames.delete();
            error_count = 0;
            result_count = 0;
            pending <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    if (error_count < 10)
                    begin
                        $display("Frame result %0d arrived with none expected, frame_number %0d",
                                 result_count, frame_number);
                    end
                    error_count++;
                end
                else
                begin
                    oldest = expected_frames.pop_front();
                    if (spike_found !== oldest.spike)
                        report_field("spike_found", 32'(oldest.spike), 32'(spike_found));
                    if (frame_change !== oldest.change)
                        report_field("frame_change", 32'(oldest.change), 32'(frame_change));
                    if (average_change !== oldest.average)
                        report_field("average_change", 32'(oldest.average),
                                     32'(average_change));
                    if (frame_number !== oldest.number)
                        report_field("frame_number", 32'(oldest.number), 32'(frame_number));
                end
                result_count++;
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_WINDOW_LEFT:   win_left = cfg_data[COORD_W-1:0];
                    REG_WINDOW_TOP:    win_top = cfg_data[COORD_W-1:0];
                    REG_WARMUP_FRAMES: warmup = cfg_data[COUNT_W-1:0];
                    REG_ARM_FRAMES:    arm = cfg_data[COUNT_W-1:0];
                    REG_SPIKE_FACTOR:  factor = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready && !frozen)
            begin
                if (int'(pixel_x) >= int'(win_left) &&
                    int'(pixel_x) < int'(win_left) + WINDOW_SIZE &&
                    int'(pixel_y) >= int'(win_top) &&
                    int'(pixel_y) < int'(win_top) + WINDOW_SIZE)
                begin
                    sum_ext = {1'b0, window_sum} + (TOTAL_W+1)'(pixel_color[23:16]);
                    window_sum = (sum_ext > (TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_MAX
                                                                      : sum_ext[TOTAL_W-1:0];
                end
                if (frame_last)
                begin
                    current = window_sum;
                    window_sum = '0;
                    change = (prev_sum > current) ? prev_sum - current : current - prev_sum;
                    prev_sum = current;

                    if (frame_count > FRAMES_W'(warmup))
                    begin
                        total_ext = {1'b0, change_sum} + (CHANGE_W+1)'(change);
                        change_sum = (total_ext > (CHANGE_W+1)'(CHANGE_MAX))
                                     ? CHANGE_MAX : total_ext[CHANGE_W-1:0];
                    end

                    average = '0;
                    if (frame_count != '0)
                    begin
                        quotient = change_sum / CHANGE_W'(frame_count);
                        average = (quotient > CHANGE_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                                     : quotient[TOTAL_W-1:0];
                    end

                    spike = 1'b0;
                    if (frame_count > FRAMES_W'(arm))
                    begin
                        threshold = PROD_W'(average) * PROD_W'(factor);
                        spike = PROD_W'(change) > threshold;
                    end

                    predicted.spike = spike;
                    predicted.change = change;
                    predicted.average = average;
                    predicted.number = frame_count;
                    expected_frames.push_back(predicted);

                    if (spike)
                        frozen = 1'b1;
                    else if (frame_count != FRAMES_MAX)
                        frame_count = frame_count + 1'b1;
                end
            end

            pending <= expected_frames.size();
            mismatches <= error_count;
        end
    end

endmodule

FILE: tb/frame_change_spike_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame change spike detector testbench
// Drives pixel beats and register writes through phases that move the window
// to the corners, fill the window densely, run unarmed, armed and frozen, and
// vary idling on both channels. The checker beside the block predicts and
// compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module frame_change_spike_detector_tb;
    import fcsd_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int RANDOM_BEATS   = 90;
    localparam int DENSE_BEATS    = 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [COORD_W-1:0]    pixel_x = '0;
    logic [COORD_W-1:0]    pixel_y = '0;
    logic [COLOR_W-1:0]    pixel_color = '0;
    logic                  frame_last = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  spike_found;
    logic [TOTAL_W-1:0]    frame_change;
    logic [TOTAL_W-1:0]    average_change;
    logic [FRAMES_W-1:0]   frame_number;

    int mismatches;
    int pending;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int cycle_count = 0;
    logic [COORD_W-1:0] cur_left = '0;
    logic [COORD_W-1:0] cur_top = '0;

    frame_change_spike_detector dut (.*);

    frame_change_spike_detector_checker frame_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                sender_idle_pct = 58;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 58;
            end
            default:
            begin
                sender_idle_pct = 27;
                receiver_stall_pct = 27;
            end
        endcase
    endtask

    task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COLOR_W-1:0] color, input logic last);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        pixel_color <= color;
        frame_last <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] base);
        int v;
        v = int'(base) + int'($urandom_range(0, 27)) - 4;
        if (v < 0 || v > 4095)
            v = int'(base);
        return COORD_W'(v);
    endfunction

    task automatic send_random_pixel();
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        if ($urandom_range(0, 9) == 0)
        begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
        end
        else
        begin
            x = near_coord(cur_left);
            y = near_coord(cur_top);
        end
        send_pixel(x, y, COLOR_W'($urandom), $urandom_range(0, 5) == 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // The 8-bit registers get random upper bits, which the block must drop.
    task automatic configure(input logic [COORD_W-1:0] left, input logic [COORD_W-1:0] top,
                             input logic [COUNT_W-1:0] warmup, input logic [COUNT_W-1:0] arm,
                             input logic [COUNT_W-1:0] factor);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(REG_WINDOW_LEFT, left);
        write_reg(REG_WINDOW_TOP, top);
        write_reg(REG_WARMUP_FRAMES, {4'($urandom), warmup});
        write_reg(REG_ARM_FRAMES, {4'($urandom), arm});
        write_reg(REG_SPIKE_FACTOR, {4'($urandom), factor});
        cfg_write <= 1'b0;
        cur_left = left;
        cur_top = top;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults, window at the origin: edges, red extremes, single-pixel
        // and empty frames, and a last pixel that is itself inside the window.
        set_idling(IDLE_NONE);
        send_pixel(12'd0, 12'd0, 24'hFFFFFF, 1'b0);
        send_pixel(12'd19, 12'd19, 24'hFF0000, 1'b0);
        send_pixel(12'd20, 12'd5, 24'hFF0000, 1'b0);
        send_pixel(12'd5, 12'd20, 24'hFF0000, 1'b0);
        send_pixel(12'd4095, 12'd4095, 24'hFFFFFF, 1'b1);
        send_pixel(12'd0, 12'd0, 24'h00FFFF, 1'b1);
        send_pixel(12'd10, 12'd10, 24'h800000, 1'b1);
        send_pixel(12'd4095, 12'd0, 24'hFFFFFF, 1'b1);
        send_pixel(12'd0, 12'd4095, 24'h7F0000, 1'b1);
        settle();

        // A window that runs past the last column and row.
        configure(12'd4090, 12'd4090, WARMUP_RESET, ARM_RESET, FACTOR_RESET);
        send_pixel(12'd4095, 12'd4095, 24'hFF0000, 1'b0);
        send_pixel(12'd4090, 12'd4090, 24'h010000, 1'b0);
        send_pixel(12'd4089, 12'd4095, 24'hFF0000, 1'b0);
        send_pixel(12'd4095, 12'd4089, 24'hFF0000, 1'b0);
        send_pixel(12'd4094, 12'd4094, 24'hFFFFFF, 1'b1);
        send_pixel(12'd0, 12'd0, 24'hFFFFFF, 1'b1);
        settle();

        configure(COORD_W'($urandom_range(0, 4076)), COORD_W'($urandom_range(0, 4076)),
                  8'd0, 8'd255, 8'd255);
        repeat (RANDOM_BEATS) send_random_pixel();
        settle();

        // One frame filled with bright pixels inside the window, then a small
        // frame after it.
        set_idling(IDLE_SENDER);
        configure(12'd100, 12'd200, 8'd0, 8'd255, 8'd255);
        repeat (DENSE_BEATS)
        begin
            send_pixel(cur_left + COORD_W'($urandom_range(0, 19)),
                       cur_top + COORD_W'($urandom_range(0, 19)),
                       {8'hFF, 16'($urandom)}, 1'b0);
        end
        send_pixel(cur_left, cur_top, 24'hFFFFFF, 1'b1);
        repeat (12) send_random_pixel();
        send_pixel(cur_left, cur_top, 24'h000000, 1'b1);
        settle();

        set_idling(IDLE_RECEIVER);
        configure(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd1);
        repeat (RANDOM_BEATS) send_random_pixel();
        settle();

        // Armed from the first frame; the large change total keeps it quiet.
        set_idling(IDLE_BOTH);
        configure(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)),
                  8'd0, 8'd0, 8'd255);
        repeat (RANDOM_BEATS) send_random_pixel();
        settle();

        // A zero factor flags the first nonzero change; after that the block
        // must take and discard every beat.
        set_idling(idle_mode_t'($urandom_range(0, 3)));
        configure(COORD_W'($urandom_range(0, 4076)), COORD_W'($urandom_range(0, 4076)),
                  8'd5, 8'd0, 8'd0);
        repeat (RANDOM_BEATS) send_random_pixel();
        settle();
        configure(12'd0, 12'd0, WARMUP_RESET, ARM_RESET, FACTOR_RESET);
        repeat (20) send_random_pixel();
        settle();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/fcsd_pkg.sv
hw/rtl/fcsd_ctrl.sv
hw/rtl/fcsd_datapath.sv
hw/rtl/frame_change_spike_detector.sv
tb/frame_change_spike_detector_checker.sv
tb/frame_change_spike_detector_tb.sv
